[rtl/core/particle_lifetime_integrator_assert.svh]
// Assertion helpers shared by the RTL that checks itself.
`ifndef PARTICLE_LIFETIME_INTEGRATOR_ASSERT_SVH
`define PARTICLE_LIFETIME_INTEGRATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PLI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("particle_lifetime_integrator: check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PLI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("particle_lifetime_integrator: check failed");

`endif

[rtl/core/plit_pkg.sv]
package plit_pkg;
  localparam int unsigned DT_W      = 16;
  localparam int unsigned LIFE_W    = 24;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned DRAG_W    = 16;
  localparam int unsigned AGE_W     = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned QUO_W     = 32;
  localparam int unsigned DRAG_DEN_W = 33;
  localparam int unsigned AGE_DEN_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRAV_X = 2'd0,
    CFG_GRAV_Y = 2'd1,
    CFG_GRAV_Z = 2'd2,
    CFG_DRAG   = 2'd3
  } cfg_idx_t;

  // Per-item data carried alongside the divider pipeline.
  typedef struct packed {
    logic                     dead;
    logic [LIFE_W-1:0]        left;
    logic                     full_life;
    logic [WORD_W-1:0]        ang;
    logic [2:0][WORD_W-1:0]   pos;
    logic [2:0][WORD_W-1:0]   vel;
    logic [DT_W-1:0]          dt;
  } side_t;

  localparam int unsigned SIDE_W = $bits(side_t);

  function automatic logic [WORD_W-1:0] sat32(input logic signed [33:0] x);
    logic [WORD_W-1:0] res;
    if (x > 34'sd2147483647) begin
      res = 32'h7FFF_FFFF;
    end else if (x < -34'sd2147483648) begin
      res = 32'h8000_0000;
    end else begin
      res = x[WORD_W-1:0];
    end
    return res;
  endfunction
endpackage

[rtl/core/plit_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module plit_div #(
  parameter int unsigned QW = plit_pkg::QUO_W,
  parameter int unsigned DW = plit_pkg::DRAG_DEN_W,
  parameter int unsigned SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [DW-1:0] in_rem,
  input  logic [QW-1:0] in_low,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_side
);
  logic [QW:0]   vld_r;
  logic [DW-1:0] rem_r  [QW+1];
  logic [QW-1:0] low_r  [QW+1];
  logic [QW-1:0] quo_r  [QW+1];
  logic [DW-1:0] den_r  [QW+1];
  logic [SW-1:0] side_r [QW+1];

  logic [DW:0]   trial_w [QW];
  logic [DW:0]   diff_w  [QW];
  logic          ge_w    [QW];
  logic [DW-1:0] rem_nxt [QW];

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      trial_w[k] = {rem_r[k], low_r[k][QW-1]};
      diff_w[k]  = trial_w[k] - {1'b0, den_r[k]};
      ge_w[k]    = trial_w[k] >= {1'b0, den_r[k]};
      rem_nxt[k] = ge_w[k] ? diff_w[k][DW-1:0] : trial_w[k][DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QW-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= in_rem;
      low_r[0]  <= in_low;
      quo_r[0]  <= '0;
      den_r[0]  <= in_den;
      side_r[0] <= in_side;
      for (int k = 0; k < QW; k++) begin
        rem_r[k+1]  <= rem_nxt[k];
        low_r[k+1]  <= {low_r[k][QW-2:0], 1'b0};
        quo_r[k+1]  <= {quo_r[k][QW-2:0], ge_w[k]};
        den_r[k+1]  <= den_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_vld  = vld_r[QW];
  assign out_quo  = quo_r[QW];
  assign out_side = side_r[QW];
endmodule

[rtl/core/particle_lifetime_integrator.sv]
// Throughput: one particle per cycle while no valid output beat is held by
// out_stall; the 32-stage quotient pipelines (drag damping per axis and
// normalized age) set the depth. A stalled valid output beat holds the
// whole pipeline in place.
// Reset (rst_n low, synchronous) clears all valid bits and the gravity and
// drag registers to zero; payload registers are not reset.
`include "particle_lifetime_integrator_assert.svh"

module particle_lifetime_integrator (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input beats
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_time_step,
  input  logic [23:0] in_life_left,
  input  logic [23:0] in_life_total,
  input  logic [31:0] in_vel_x,
  input  logic [31:0] in_vel_y,
  input  logic [31:0] in_vel_z,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  input  logic [31:0] in_angle,
  input  logic [31:0] in_spin_rate,
  // result beats
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_alive,
  output logic [23:0] out_life_out,
  output logic [16:0] out_age_frac,
  output logic [31:0] out_vel_out_x,
  output logic [31:0] out_vel_out_y,
  output logic [31:0] out_vel_out_z,
  output logic [31:0] out_pos_out_x,
  output logic [31:0] out_pos_out_y,
  output logic [31:0] out_pos_out_z,
  output logic [31:0] out_angle_out
);
  localparam int unsigned QW  = plit_pkg::QUO_W;
  localparam int unsigned DDW = plit_pkg::DRAG_DEN_W;
  localparam int unsigned ADW = plit_pkg::AGE_DEN_W;

  // Global advance: move every stage unless a finished beat is held.
  logic out_valid_r;
  logic en;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // Configuration registers.
  logic [31:0] grav_r [3];
  logic [15:0] drag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r[0] <= '0;
      grav_r[1] <= '0;
      grav_r[2] <= '0;
      drag_r    <= '0;
    end else if (cfg_wr_en) begin
      unique case (plit_pkg::cfg_idx_t'(cfg_index))
        plit_pkg::CFG_GRAV_X: grav_r[0] <= cfg_data;
        plit_pkg::CFG_GRAV_Y: grav_r[1] <= cfg_data;
        plit_pkg::CFG_GRAV_Z: grav_r[2] <= cfg_data;
        plit_pkg::CFG_DRAG:   drag_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Stage A: capture the input beat.
  logic        a_vld_r;
  logic [15:0] a_dt_r;
  logic [23:0] a_life_r, a_total_r;
  logic [31:0] a_vel_r [3];
  logic [31:0] a_pos_r [3];
  logic [31:0] a_ang_r, a_spin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_dt_r    <= in_time_step;
      a_life_r  <= in_life_left;
      a_total_r <= in_life_total;
      a_vel_r[0] <= in_vel_x;
      a_vel_r[1] <= in_vel_y;
      a_vel_r[2] <= in_vel_z;
      a_pos_r[0] <= in_pos_x;
      a_pos_r[1] <= in_pos_y;
      a_pos_r[2] <= in_pos_z;
      a_ang_r   <= in_angle;
      a_spin_r  <= in_spin_rate;
    end
  end

  // Stage B: register the step products (gravity, spin, drag).
  logic               b_vld_r;
  logic [15:0]        b_dt_r;
  logic [23:0]        b_life_r, b_total_r;
  logic [31:0]        b_vel_r [3];
  logic [31:0]        b_pos_r [3];
  logic [31:0]        b_ang_r;
  logic signed [48:0] b_gp_r [3];
  logic signed [48:0] b_sp_r;
  logic [31:0]        b_dp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_dt_r    <= a_dt_r;
      b_life_r  <= a_life_r;
      b_total_r <= a_total_r;
      b_ang_r   <= a_ang_r;
      for (int i = 0; i < 3; i++) begin
        b_vel_r[i] <= a_vel_r[i];
        b_pos_r[i] <= a_pos_r[i];
        b_gp_r[i]  <= $signed(grav_r[i]) * $signed({1'b0, a_dt_r});
      end
      b_sp_r <= $signed(a_spin_r) * $signed({1'b0, a_dt_r});
      b_dp_r <= drag_r * a_dt_r;
    end
  end

  // Gravity kick, saturation, sign split and denominator feed the dividers.
  logic [31:0]   vsat_w [3];
  logic [31:0]   mag_w  [3];
  logic          neg_w  [3];
  logic [23:0]   left_w;
  logic [DDW-1:0] den_w;
  plit_pkg::side_t side_w;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vsat_w[i] = plit_pkg::sat32({{2{b_vel_r[i][31]}}, b_vel_r[i]}
                                  + {{2{b_gp_r[i][47]}}, b_gp_r[i][47:16]});
      neg_w[i]  = vsat_w[i][31];
      mag_w[i]  = neg_w[i] ? (32'd0 - vsat_w[i]) : vsat_w[i];
    end
    left_w           = b_life_r - {8'd0, b_dt_r};
    den_w            = {1'b1, 24'd0} + {1'b0, b_dp_r};
    side_w.dead      = b_life_r <= {8'd0, b_dt_r};
    side_w.left      = left_w;
    side_w.full_life = left_w >= b_total_r;
    side_w.ang       = side_w.dead ? b_ang_r : (b_ang_r + b_sp_r[47:16]);
    for (int i = 0; i < 3; i++) begin
      side_w.pos[i] = b_pos_r[i];
      side_w.vel[i] = b_vel_r[i];
    end
    side_w.dt = b_dt_r;
  end

  // Drag damping: |v| * 2^24 / denom, one lane per axis.
  logic [QW-1:0] dq_w   [3];
  logic          dneg_w [3];
  logic          dvld_w [3];

  for (genvar g = 0; g < 3; g++) begin : g_drag
    plit_div #(.QW(QW), .DW(DDW), .SW(1)) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (b_vld_r),
      .in_rem   ({9'd0, mag_w[g][31:8]}),
      .in_low   ({mag_w[g][7:0], 24'd0}),
      .in_den   (den_w),
      .in_side  (neg_w[g]),
      .out_vld  (dvld_w[g]),
      .out_quo  (dq_w[g]),
      .out_side (dneg_w[g])
    );
  end

  // Life ratio: life_out * 2^16 / life_total; it also carries the side data.
  logic            age_vld_w;
  logic [QW-1:0]   age_q_w;
  logic [plit_pkg::SIDE_W-1:0] side_out_w;
  plit_pkg::side_t side_q;

  plit_div #(.QW(QW), .DW(ADW), .SW(plit_pkg::SIDE_W)) u_age_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (b_vld_r),
    .in_rem   ({16'd0, left_w[23:16]}),
    .in_low   ({left_w[15:0], 16'd0}),
    .in_den   (b_total_r),
    .in_side  (side_w),
    .out_vld  (age_vld_w),
    .out_quo  (age_q_w),
    .out_side (side_out_w)
  );
  assign side_q = plit_pkg::side_t'(side_out_w);

  // Stage C: restore velocity sign, finish the age.
  logic               c_vld_r;
  logic signed [32:0] c_vel_r [3];
  logic [16:0]        c_age_r;
  plit_pkg::side_t    c_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= age_vld_w;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c_vel_r[i] <= dneg_w[i] ? (33'sd0 - $signed({1'b0, dq_w[i]}))
                                : $signed({1'b0, dq_w[i]});
      end
      c_age_r  <= side_q.full_life ? 17'd0 : (17'd65536 - {1'b0, age_q_w[15:0]});
      c_side_r <= side_q;
    end
  end

  // Stage D: position step product.
  logic               d_vld_r;
  logic signed [49:0] d_pp_r  [3];
  logic [31:0]        d_vel_r [3];
  logic [16:0]        d_age_r;
  plit_pkg::side_t    d_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_pp_r[i]  <= c_vel_r[i] * $signed({1'b0, c_side_r.dt});
        d_vel_r[i] <= c_vel_r[i][31:0];
      end
      d_age_r  <= c_age_r;
      d_side_r <= c_side_r;
    end
  end

  // Output register: integrate position; a dead particle passes through.
  logic        out_alive_r;
  logic [23:0] out_life_r;
  logic [16:0] out_age_r;
  logic [31:0] out_vel_r [3];
  logic [31:0] out_pos_r [3];
  logic [31:0] out_ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_alive_r <= !d_side_r.dead;
      out_life_r  <= d_side_r.dead ? 24'd0 : d_side_r.left;
      out_age_r   <= d_side_r.dead ? 17'd65536 : d_age_r;
      out_ang_r   <= d_side_r.ang;
      for (int i = 0; i < 3; i++) begin
        if (d_side_r.dead) begin
          out_vel_r[i] <= d_side_r.vel[i];
          out_pos_r[i] <= d_side_r.pos[i];
        end else begin
          out_vel_r[i] <= d_vel_r[i];
          out_pos_r[i] <= plit_pkg::sat32({{2{d_side_r.pos[i][31]}}, d_side_r.pos[i]}
                                          + {{2{d_pp_r[i][47]}}, d_pp_r[i][47:16]});
        end
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_alive     = out_alive_r;
  assign out_life_out  = out_life_r;
  assign out_age_frac  = out_age_r;
  assign out_vel_out_x = out_vel_r[0];
  assign out_vel_out_y = out_vel_r[1];
  assign out_vel_out_z = out_vel_r[2];
  assign out_pos_out_x = out_pos_r[0];
  assign out_pos_out_y = out_pos_r[1];
  assign out_pos_out_z = out_pos_r[2];
  assign out_angle_out = out_ang_r;

  // Dead beats report zero life and full age; live beats keep some life.
  `PLI_ASSERT_NOW(a_dead_aged, out_valid_r && !out_alive_r, out_life_r == 24'd0 && out_age_r == 17'd65536)
  `PLI_ASSERT_NOW(a_alive_life, out_valid_r && out_alive_r, out_life_r != 24'd0)
  // A held stage keeps its beat while the output is stalled.
  `PLI_ASSERT_NEXT(a_hold_stage, d_vld_r && !en, d_vld_r && $stable(d_side_r))
  // Divider lanes stay in lockstep.
  `PLI_ASSERT_NOW(a_lanes_sync, age_vld_w, dvld_w[0] && dvld_w[1] && dvld_w[2])
endmodule
